// ===== rtl/core/xtkb_pkg.sv =====
// shared types, constants and the key table of the xt keyboard interface
`timescale 1ns / 1ps
`default_nettype none

package xtkb_pkg;

    localparam int KEY_ROWS = 98;
    localparam logic [6:0] SLASH_ROW = 7'd95;

    localparam logic [7:0] BAT_KEY    = 8'h55;
    localparam logic [7:0] BAT_OK     = 8'haa;
    localparam logic [7:0] EXT_PREFIX = 8'he0;
    localparam logic [7:0] BREAK_BIT  = 8'h80;

    localparam logic [15:0] RESET_DELAY = 16'd381;

    localparam logic [1:0] IRQ_NONE  = 2'd0;
    localparam logic [1:0] IRQ_LOW   = 2'd1;
    localparam logic [1:0] IRQ_RAISE = 2'd2;

    typedef enum logic [2:0] {
        KIND_DOWN   = 3'd0,
        KIND_UP     = 3'd1,
        KIND_RAW    = 3'd2,
        KIND_CLOCK  = 3'd3,
        KIND_ENABLE = 3'd4,
        KIND_TICK   = 3'd5
    } t_kind;

    // what the result stage does to the latched key
    typedef enum logic [1:0] {
        KEY_HOLD  = 2'd0,
        KEY_LOAD  = 2'd1,
        KEY_BAT   = 2'd2,
        KEY_CLEAR = 2'd3
    } t_key_op;

    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  key_index;
        logic [7:0]  data_value;
        logic [15:0] tick_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] scan_code;
        logic       key_pending;
        logic [1:0] irq_event;
        logic       overflow;
        logic [7:0] buffered_count;
    } t_out_item;

    typedef struct packed {
        t_key_op    key_op;
        logic       key_pending;
        logic [1:0] irq_event;
        logic       overflow;
        logic [7:0] buffered_count;
    } t_stage;

    function automatic logic [7:0] make_code(input logic [6:0] row);
        logic [7:0] code;
        begin
            if (row <= 7'd28) begin
                code = 8'(row) + 8'd1;
            end else if (row <= 7'd70) begin
                code = 8'(row);
            end else begin
                case (row) inside
                    7'd71, 7'd72: code = 8'h47;
                    7'd73, 7'd74: code = 8'h48;
                    7'd75, 7'd76: code = 8'h49;
                    7'd77:        code = 8'h4a;
                    7'd78, 7'd79: code = 8'h4b;
                    7'd80:        code = 8'h4c;
                    7'd81, 7'd82: code = 8'h4d;
                    7'd83:        code = 8'h4e;
                    7'd84, 7'd85: code = 8'h4f;
                    7'd86, 7'd87: code = 8'h50;
                    7'd88, 7'd89: code = 8'h51;
                    7'd90:        code = 8'h1c;
                    7'd91, 7'd92: code = 8'h52;
                    7'd93, 7'd94: code = 8'h53;
                    7'd95:        code = 8'h35;
                    7'd96:        code = 8'h57;
                    7'd97:        code = 8'h58;
                    default:      code = 8'h00;
                endcase
            end
            return code;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xt_keyboard_scan_code_interface_top.sv =====
// top level of the xt keyboard scan code interface
// path: a transaction passes the input register, the middle stage register and the output result register
// throughput: one transaction per cycle while the output does not stall; a keypad
//   slash sequence pushing two bytes holds the input for the single fifo write port
// reset: synchronous active low; the fifo ram is not cleared, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module xt_keyboard_scan_code_interface_top #(
    parameter int FIFO_DEPTH = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire xtkb_pkg::t_in_item   i_in_item,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output xtkb_pkg::t_out_item       o_out_item,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_cfg_valid,
    input  wire logic [15:0]          i_cfg_data,
    output logic                      o_cfg_ready
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic              ram_we;
    logic [PW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [PW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;
    logic              b_valid;
    xtkb_pkg::t_stage  b_stage;
    logic              b_free;

    assign o_cfg_ready = 1'b1;

    xtkb_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_b_valid   (b_valid),
        .o_b         (b_stage),
        .i_b_free    (b_free)
    );

    xtkb_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    xtkb_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_b_valid   (b_valid),
        .i_b         (b_stage),
        .o_b_free    (b_free),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // a dropped byte means the ring was left full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow
        |-> o_out_item.buffered_count == 8'(FIFO_DEPTH - 1))
        else $error("overflow reported with free fifo space");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.irq_event == xtkb_pkg::IRQ_RAISE
        |-> o_out_item.key_pending)
        else $error("interrupt raised without a pending key");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.irq_event == xtkb_pkg::IRQ_LOW
        |-> !o_out_item.key_pending && o_out_item.scan_code == 8'h00)
        else $error("interrupt lowered but key not cleared");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.irq_event == xtkb_pkg::IRQ_RAISE
        |-> !o_out_item.overflow)
        else $error("key delivered together with a push");

endmodule

`default_nettype wire

// ===== rtl/core/xtkb_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module xtkb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/xtkb_ctrl.sv =====
// input register, key and fifo control state, and the middle stage register
`timescale 1ns / 1ps
`default_nettype none

module xtkb_ctrl #(
    parameter int FIFO_DEPTH = 256,
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire xtkb_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    input  wire logic                i_cfg_valid,
    input  wire logic [15:0]         i_cfg_data,
    output logic                     o_ram_we,
    output logic [PW-1:0]            o_ram_waddr,
    output logic [7:0]               o_ram_wdata,
    output logic                     o_ram_re,
    output logic [PW-1:0]            o_ram_raddr,
    output logic                     o_b_valid,
    output xtkb_pkg::t_stage         o_b,
    input  wire logic                i_b_free
);

    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    logic                      r_a_valid;
    xtkb_pkg::t_in_item        r_a_item;
    logic                      r_b_valid;
    xtkb_pkg::t_stage          r_b;
    logic                      r_pend, n_pend;
    logic [PW-1:0]             r_pend_addr, n_pend_addr;
    logic [7:0]                r_pend_data, n_pend_data;
    logic [xtkb_pkg::KEY_ROWS-1:0] r_marks, n_marks;
    logic [PW-1:0]             r_rp, n_rp;
    logic [PW-1:0]             r_wp, n_wp;
    logic [15:0]               r_counter, n_counter;
    logic [15:0]               r_reload;
    logic                      r_lvalid, n_lvalid;
    logic                      r_clock, n_clock;
    logic                      r_enable, n_enable;
    xtkb_pkg::t_stage          n_b;
    logic                      n_we;
    logic [PW-1:0]             n_waddr;
    logic [7:0]                n_wdata;
    logic                      n_re;
    logic                      a_move;
    logic                      in_take;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    assign a_move     = r_a_valid && i_b_free && !r_pend;
    assign o_in_stall = r_a_valid && !a_move;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        logic          level;
        logic          in_table;
        logic [1:0]    push_cnt;
        logic [7:0]    b0;
        logic [7:0]    b1;
        logic [7:0]    code;
        logic [PW-1:0] wp1;
        logic [PW-1:0] wp2;
        logic [PW:0]   cnt;

        level    = |r_a_item.data_value;
        in_table = r_a_item.key_index < 7'(xtkb_pkg::KEY_ROWS);
        push_cnt = 2'd0;
        b0       = 8'h00;
        b1       = 8'h00;
        code     = xtkb_pkg::make_code(r_a_item.key_index);
        wp1      = ptr_inc(r_wp);
        wp2      = ptr_inc(wp1);

        n_marks     = r_marks;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_counter   = r_counter;
        n_lvalid    = r_lvalid;
        n_clock     = r_clock;
        n_enable    = r_enable;
        n_pend      = 1'b0;
        n_pend_addr = wp1;
        n_pend_data = b1;
        n_we        = 1'b0;
        n_waddr     = r_wp;
        n_wdata     = b0;
        n_re        = 1'b0;
        n_b.key_op    = xtkb_pkg::KEY_HOLD;
        n_b.irq_event = xtkb_pkg::IRQ_NONE;
        n_b.overflow  = 1'b0;

        unique case (xtkb_pkg::t_kind'(r_a_item.kind)) inside
            xtkb_pkg::KIND_DOWN, xtkb_pkg::KIND_UP: begin
                if (in_table) begin
                    if (r_a_item.kind == xtkb_pkg::KIND_DOWN) begin
                        n_marks[r_a_item.key_index] = 1'b1;
                        push_cnt = 2'd1;
                    end else if (r_marks[r_a_item.key_index]) begin
                        n_marks[r_a_item.key_index] = 1'b0;
                        push_cnt = 2'd1;
                        code = code | xtkb_pkg::BREAK_BIT;
                    end
                    if (push_cnt != 2'd0 && r_a_item.key_index == xtkb_pkg::SLASH_ROW) begin
                        push_cnt = 2'd2;
                        b0 = xtkb_pkg::EXT_PREFIX;
                        b1 = code;
                    end else begin
                        b0 = code;
                    end
                end
            end
            xtkb_pkg::KIND_RAW: begin
                push_cnt = 2'd1;
                b0 = r_a_item.data_value;
            end
            xtkb_pkg::KIND_CLOCK: begin
                if (r_clock != level) begin
                    n_clock = level;
                    if (level) begin
                        n_marks    = '0;
                        n_counter  = r_reload;
                        n_b.key_op = xtkb_pkg::KEY_BAT;
                        n_rp       = '0;
                        n_wp       = PW'(1);
                        n_we       = 1'b1;
                        n_waddr    = '0;
                        n_wdata    = xtkb_pkg::BAT_OK;
                    end
                end
            end
            xtkb_pkg::KIND_ENABLE: begin
                if (r_enable != level) begin
                    n_enable = level;
                    if (level) begin
                        n_counter = r_reload;
                    end else begin
                        n_b.key_op    = xtkb_pkg::KEY_CLEAR;
                        n_lvalid      = 1'b0;
                        n_b.irq_event = xtkb_pkg::IRQ_LOW;
                    end
                end
            end
            xtkb_pkg::KIND_TICK: begin
                if (r_rp != r_wp && r_clock && r_enable && !r_lvalid) begin
                    if (r_counter > r_a_item.tick_count) begin
                        n_counter = r_counter - r_a_item.tick_count;
                    end else begin
                        n_counter     = r_reload;
                        n_b.key_op    = xtkb_pkg::KEY_LOAD;
                        n_re          = 1'b1;
                        n_lvalid      = 1'b1;
                        n_rp          = ptr_inc(r_rp);
                        n_b.irq_event = xtkb_pkg::IRQ_RAISE;
                    end
                end
            end
            default: begin
            end
        endcase

        // second byte of an extended sequence is held in the pend register and goes to the ram in the next cycle
        if (push_cnt != 2'd0) begin
            if (wp1 == r_rp) begin
                n_b.overflow = 1'b1;
            end else begin
                n_we    = 1'b1;
                n_waddr = r_wp;
                n_wdata = b0;
                n_wp    = wp1;
                if (push_cnt == 2'd2) begin
                    if (wp2 == r_rp) begin
                        n_b.overflow = 1'b1;
                    end else begin
                        n_pend      = 1'b1;
                        n_pend_addr = wp1;
                        n_pend_data = b1;
                        n_wp        = wp2;
                    end
                end
            end
        end

        cnt = {1'b0, n_wp} - {1'b0, n_rp};
        if (n_wp < n_rp) begin
            cnt = cnt + (PW + 1)'(FIFO_DEPTH);
        end
        n_b.buffered_count = 8'(cnt);
        n_b.key_pending    = n_lvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_pend    <= 1'b0;
            r_marks   <= '0;
            r_rp      <= '0;
            r_wp      <= '0;
            r_counter <= xtkb_pkg::RESET_DELAY;
            r_reload  <= xtkb_pkg::RESET_DELAY;
            r_lvalid  <= 1'b0;
            r_clock   <= 1'b0;
            r_enable  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_reload <= i_cfg_data;
            end
            if (in_take) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (i_b_free) begin
                r_b_valid <= 1'b0;
            end
            if (r_pend) begin
                r_pend <= 1'b0;
            end else if (a_move) begin
                r_pend <= n_pend;
            end
            if (a_move) begin
                r_marks   <= n_marks;
                r_rp      <= n_rp;
                r_wp      <= n_wp;
                r_counter <= n_counter;
                r_lvalid  <= n_lvalid;
                r_clock   <= n_clock;
                r_enable  <= n_enable;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_item <= i_in_item;
        end
        if (a_move) begin
            r_b         <= n_b;
            r_pend_addr <= n_pend_addr;
            r_pend_data <= n_pend_data;
        end
    end

    assign o_ram_we    = r_pend || (a_move && n_we);
    assign o_ram_waddr = r_pend ? r_pend_addr : n_waddr;
    assign o_ram_wdata = r_pend ? r_pend_data : n_wdata;
    assign o_ram_re    = a_move && n_re;
    assign o_ram_raddr = r_rp;
    assign o_b_valid   = r_b_valid;
    assign o_b         = r_b;

endmodule

`default_nettype wire

// ===== rtl/core/xtkb_out.sv =====
// latched key register and output result register
`timescale 1ns / 1ps
`default_nettype none

module xtkb_out (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_b_valid,
    input  wire xtkb_pkg::t_stage    i_b,
    output logic                     o_b_free,
    input  wire logic [7:0]          i_ram_rdata,
    output logic                     o_out_valid,
    output xtkb_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall
);

    logic                 r_out_valid;
    xtkb_pkg::t_out_item  r_out_item;
    logic [7:0]           r_key, n_key;
    logic                 b_move;

    assign o_b_free = !r_out_valid || !i_out_stall;
    assign b_move   = i_b_valid && o_b_free;

    always_comb begin
        case (i_b.key_op)
            xtkb_pkg::KEY_LOAD:  n_key = i_ram_rdata;
            xtkb_pkg::KEY_BAT:   n_key = xtkb_pkg::BAT_KEY;
            xtkb_pkg::KEY_CLEAR: n_key = 8'h00;
            default:             n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_key       <= 8'h00;
        end else begin
            if (b_move) begin
                r_out_valid <= 1'b1;
                r_key       <= n_key;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_out_item.scan_code      <= n_key;
            r_out_item.key_pending    <= i_b.key_pending;
            r_out_item.irq_event      <= i_b.irq_event;
            r_out_item.overflow       <= i_b.overflow;
            r_out_item.buffered_count <= i_b.buffered_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== sim/xt_keyboard_scan_code_interface_top_tb.sv =====
// self-checking testbench of the xt keyboard scan code interface with a built-in predictor
`timescale 1ns / 1ps

module xt_keyboard_scan_code_interface_top_tb;

    // kind codes outside the defined set, the block must leave its state alone
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    xtkb_pkg::t_in_item  in_item   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [15:0]         cfg_data  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic                o_cfg_ready;
    xtkb_pkg::t_out_item o_out_item;

    xt_keyboard_scan_code_interface_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // make codes of the key rows
    logic [7:0] make_table [xtkb_pkg::KEY_ROWS] = '{
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
        8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1d,
        8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31,
        8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h3b,
        8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
        8'h46, 8'h47, 8'h47, 8'h48, 8'h48, 8'h49, 8'h49, 8'h4a, 8'h4b, 8'h4b,
        8'h4c, 8'h4d, 8'h4d, 8'h4e, 8'h4f, 8'h4f, 8'h50, 8'h50, 8'h51, 8'h51,
        8'h1c, 8'h52, 8'h52, 8'h53, 8'h53, 8'h35, 8'h57, 8'h58
    };

    // predicted keyboard state
    logic [15:0] delay_reload = xtkb_pkg::RESET_DELAY;
    logic [15:0] delay_left   = xtkb_pkg::RESET_DELAY;
    logic        key_is_down [xtkb_pkg::KEY_ROWS] = '{default: 1'b0};
    logic [7:0]  code_ring [256];
    logic [7:0]  ring_rd    = '0;
    logic [7:0]  ring_wr    = '0;
    logic [7:0]  held_code  = '0;
    logic        held_valid = 1'b0;
    logic        clk_line   = 1'b0;
    logic        en_line    = 1'b0;

    xtkb_pkg::t_in_item  items_to_send [$];
    xtkb_pkg::t_out_item results_due [$];

    int   items_queued    = 0;
    int   items_taken     = 0;
    int   results_checked = 0;
    int   fail_count      = 0;
    int   gap_left        = 0;
    int   hold_left       = 0;
    int   quiet_cycles    = 0;
    logic long_hold_done  = 1'b0;
    logic idling          = 1'b0;

    function automatic logic ring_push(logic [7:0] code);
        logic [7:0] next;
        next = ring_wr + 8'd1;
        if (next == ring_rd) begin
            return 1'b1;
        end
        code_ring[ring_wr] = code;
        ring_wr = next;
        return 1'b0;
    endfunction

    function automatic xtkb_pkg::t_out_item advance_keyboard(xtkb_pkg::t_in_item it);
        xtkb_pkg::t_out_item res;
        logic                level;
        logic                spill;
        logic [1:0]          irq;
        logic [7:0]          code;
        level = (it.data_value != 8'd0);
        spill = 1'b0;
        irq   = xtkb_pkg::IRQ_NONE;
        case (it.kind) inside
            xtkb_pkg::KIND_DOWN, xtkb_pkg::KIND_UP: begin
                if (it.key_index < xtkb_pkg::KEY_ROWS) begin
                    if (it.kind == xtkb_pkg::KIND_DOWN || key_is_down[it.key_index]) begin
                        key_is_down[it.key_index] = (it.kind == xtkb_pkg::KIND_DOWN);
                        code = make_table[it.key_index]
                             | ((it.kind == xtkb_pkg::KIND_UP) ? xtkb_pkg::BREAK_BIT : 8'h00);
                        // a full fifo drops the rest of the sequence
                        if (it.key_index == xtkb_pkg::SLASH_ROW) begin
                            spill = ring_push(xtkb_pkg::EXT_PREFIX);
                        end
                        if (!spill) begin
                            spill = ring_push(code);
                        end
                    end
                end
            end
            xtkb_pkg::KIND_RAW: begin
                spill = ring_push(it.data_value);
            end
            xtkb_pkg::KIND_CLOCK: begin
                if (level != clk_line) begin
                    clk_line = level;
                    if (level) begin
                        foreach (key_is_down[r]) key_is_down[r] = 1'b0;
                        delay_left    = delay_reload;
                        held_code     = xtkb_pkg::BAT_KEY;
                        code_ring[0]  = xtkb_pkg::BAT_OK;
                        ring_rd       = 8'd0;
                        ring_wr       = 8'd1;
                    end
                end
            end
            xtkb_pkg::KIND_ENABLE: begin
                if (level != en_line) begin
                    en_line = level;
                    if (level) begin
                        delay_left = delay_reload;
                    end else begin
                        held_code  = 8'h00;
                        held_valid = 1'b0;
                        irq        = xtkb_pkg::IRQ_LOW;
                    end
                end
            end
            xtkb_pkg::KIND_TICK: begin
                if (ring_rd != ring_wr && clk_line && en_line && !held_valid) begin
                    if (delay_left > it.tick_count) begin
                        delay_left = delay_left - it.tick_count;
                    end else begin
                        delay_left = delay_reload;
                        held_code  = code_ring[ring_rd];
                        held_valid = 1'b1;
                        ring_rd    = ring_rd + 8'd1;
                        irq        = xtkb_pkg::IRQ_RAISE;
                    end
                end
            end
            default: ;
        endcase
        res.scan_code      = held_code;
        res.key_pending    = held_valid;
        res.irq_event      = irq;
        res.overflow       = spill;
        res.buffered_count = ring_wr - ring_rd;
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // sender side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                results_due.push_back(advance_keyboard(in_item));
                items_taken <= items_taken + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (idling && $urandom_range(0, 7) == 0) begin
                    gap_left <= $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    in_item  <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side
    always @(posedge i_clk) begin : receiver
        xtkb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_checked <= results_checked + 1;
            if (results_due.size() == 0) begin
                $error("result with no transaction waiting for it");
                fail_count++;
            end else begin
                want = results_due.pop_front();
                check_field("scan_code", want.scan_code, o_out_item.scan_code);
                check_field("key_pending", 8'(want.key_pending), 8'(o_out_item.key_pending));
                check_field("irq_event", 8'(want.irq_event), 8'(o_out_item.irq_event));
                check_field("overflow", 8'(want.overflow), 8'(o_out_item.overflow));
                check_field("buffered_count", want.buffered_count,
                            o_out_item.buffered_count);
            end
        end
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (!long_hold_done && items_taken >= 300) begin
            // long hold so the pipeline fills and backs up into the input
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_stall      <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            hold_left <= $urandom_range(0, 9);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic queue_item(logic [2:0] kind, logic [6:0] row, logic [7:0] data,
                              logic [15:0] ticks);
        xtkb_pkg::t_in_item it;
        it.kind       = kind;
        it.key_index  = row;
        it.data_value = data;
        it.tick_count = ticks;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    function automatic logic [6:0] rand_row();
        case ($urandom_range(0, 9))
            0: return 7'($urandom_range(98, 127));
            1: return xtkb_pkg::SLASH_ROW;
            default: return 7'($urandom_range(0, 97));
        endcase
    endfunction

    function automatic logic [15:0] rand_ticks();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 2 * int'(delay_reload)));
        endcase
    endfunction

    task automatic wait_drained();
        while (results_checked < items_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_delay(logic [15:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid    <= 1'b0;
        delay_reload = value;
    endtask

    task automatic send_directed();
        queue_item(xtkb_pkg::KIND_RAW, 7'h7f, 8'h00, 16'hffff);
        queue_item(xtkb_pkg::KIND_RAW, 7'h00, 8'hff, 16'h0000);
        queue_item(xtkb_pkg::KIND_DOWN, 7'd0, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_DOWN, 7'd97, 8'hff, 16'hffff);
        queue_item(xtkb_pkg::KIND_DOWN, xtkb_pkg::SLASH_ROW, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_UP, xtkb_pkg::SLASH_ROW, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_UP, 7'd97, 8'h00, 16'h0000);
        // never pressed, no break code
        queue_item(xtkb_pkg::KIND_UP, 7'd50, 8'h00, 16'h0000);
        // rows past the table
        queue_item(xtkb_pkg::KIND_DOWN, 7'd98, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_UP, 7'd127, 8'h00, 16'h0000);
        queue_item(KIND_SPARE_LO, 7'h7f, 8'hff, 16'hffff);
        queue_item(KIND_SPARE_HI, 7'h7f, 8'hff, 16'hffff);
        queue_item(xtkb_pkg::KIND_TICK, 7'h00, 8'h00, 16'hffff);
        queue_item(xtkb_pkg::KIND_CLOCK, 7'h00, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_CLOCK, 7'h00, 8'h80, 16'h0000);
        queue_item(xtkb_pkg::KIND_CLOCK, 7'h00, 8'h01, 16'h0000);
        queue_item(xtkb_pkg::KIND_RAW, 7'h00, 8'h5a, 16'h0000);
        queue_item(xtkb_pkg::KIND_ENABLE, 7'h00, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_ENABLE, 7'h00, 8'hff, 16'h0000);
        queue_item(xtkb_pkg::KIND_TICK, 7'h00, 8'h00, 16'd0);
        queue_item(xtkb_pkg::KIND_TICK, 7'h00, 8'h00, 16'd380);
        queue_item(xtkb_pkg::KIND_TICK, 7'h00, 8'h00, 16'd1);
        // key pending, counter must hold
        queue_item(xtkb_pkg::KIND_TICK, 7'h00, 8'h00, 16'hffff);
        queue_item(xtkb_pkg::KIND_ENABLE, 7'h00, 8'h00, 16'h0000);
        queue_item(xtkb_pkg::KIND_ENABLE, 7'h00, 8'h01, 16'h0000);
        queue_item(xtkb_pkg::KIND_TICK, 7'h00, 8'h00, 16'hffff);
        queue_item(xtkb_pkg::KIND_CLOCK, 7'h00, 8'h00, 16'h0000);
    endtask

    // line up clock and enable, then let ticks deliver a byte
    task automatic send_delivery();
        if ($urandom_range(0, 5) == 0) begin
            queue_item(xtkb_pkg::KIND_CLOCK, 7'($urandom), 8'h00, 16'($urandom));
        end
        queue_item(xtkb_pkg::KIND_CLOCK, 7'($urandom), 8'($urandom_range(1, 255)),
                   16'($urandom));
        queue_item(xtkb_pkg::KIND_ENABLE, 7'($urandom), 8'h00, 16'($urandom));
        queue_item(xtkb_pkg::KIND_ENABLE, 7'($urandom), 8'($urandom_range(1, 255)),
                   16'($urandom));
        repeat ($urandom_range(0, 3)) begin
            queue_item(xtkb_pkg::KIND_RAW, 7'($urandom), 8'($urandom), 16'($urandom));
        end
        repeat ($urandom_range(1, 4)) begin
            queue_item(xtkb_pkg::KIND_TICK, 7'($urandom), 8'($urandom), rand_ticks());
        end
    endtask

    task automatic send_keys();
        logic [6:0] row;
        repeat ($urandom_range(1, 6)) begin
            row = rand_row();
            queue_item(xtkb_pkg::KIND_DOWN, row, 8'($urandom), 16'($urandom));
            if ($urandom_range(0, 3) != 0) begin
                queue_item(xtkb_pkg::KIND_UP, row, 8'($urandom), 16'($urandom));
            end else begin
                queue_item(xtkb_pkg::KIND_UP, rand_row(), 8'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            queue_item(3'($urandom), 7'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    // fill the fifo to or near the brim so the slash sequence can hit the full mark at its first or second byte
    task automatic send_fill();
        queue_item(xtkb_pkg::KIND_CLOCK, 7'($urandom), 8'h00, 16'($urandom));
        queue_item(xtkb_pkg::KIND_CLOCK, 7'($urandom), 8'($urandom_range(1, 255)),
                   16'($urandom));
        queue_item(xtkb_pkg::KIND_ENABLE, 7'($urandom), 8'h00, 16'($urandom));
        repeat ($urandom_range(252, 254)) begin
            queue_item(xtkb_pkg::KIND_RAW, 7'($urandom), 8'($urandom), 16'($urandom));
        end
        queue_item(xtkb_pkg::KIND_DOWN, xtkb_pkg::SLASH_ROW, 8'($urandom), 16'($urandom));
        queue_item(xtkb_pkg::KIND_RAW, 7'($urandom), 8'($urandom), 16'($urandom));
        queue_item(xtkb_pkg::KIND_UP, xtkb_pkg::SLASH_ROW, 8'($urandom), 16'($urandom));
    endtask

    task automatic send_random(int count);
        int stop;
        int pick;
        stop = items_queued + count;
        while (items_queued < stop) begin
            pick = $urandom_range(0, 299);
            if (pick == 0) begin
                send_fill();
            end else if (pick < 135) begin
                send_delivery();
            end else if (pick < 225) begin
                send_keys();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idling  <= 1'b1;
        send_directed();
        wait_drained();
        write_delay(16'd1);
        send_fill();
        send_random(300);
        wait_drained();
        write_delay(16'hffff);
        send_random(400);
        wait_drained();
        write_delay(16'($urandom_range(2, 65534)));
        send_random(450);
        wait_drained();
        idling <= 1'b0;
        write_delay(16'($urandom_range(1, 600)));
        send_random(600);
        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
